// File: hdl/mon_pkg.sv
// mon_pkg: shared types and constants of the morton octree node builder
// sequencer state codes, register indexes, field widths, level store controls
// no dependencies
package mon_pkg;

  localparam int KEY_IN_W  = 30;
  localparam int NKEY_W    = 31;
  localparam int NLVL_W    = 4;
  localparam int CNT_W     = 17;
  localparam int MASK_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 31;
  localparam int CNT_MAX   = 131071;

  localparam logic [CFG_IDX_W-1:0] CFG_USE_INTERVAL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_BEGIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_END   = 2'd2;

  localparam logic [CFG_W-1:0] INTERVAL_END_RST = 31'h4000_0000;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ERR  = 6'b000010,
    ST_SCAN = 6'b000100,
    ST_EMIT = 6'b001000,
    ST_INCR = 6'b010000,
    ST_ROOT = 6'b100000
  } mon_state_t;

  typedef struct packed {
    logic incr;
    logic mask_set;
    logic clear_above;
    logic clear_all;
  } mon_store_ctl_t;

endpackage

// File: hdl/mon_level_store.sv
// mon_level_store: per-level particle counts and child masks of the open path
// one read port at a sequencer-chosen level, parallel increment and clears
// depends on mon_pkg
module mon_level_store #(
  parameter int TREE_DEPTH = 10,
  parameter int MAX_POINTS = 65536
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mon_pkg::mon_store_ctl_t              ctl,
  input  logic [$clog2(TREE_DEPTH+1)-1:0]      rd_lvl,
  input  logic [$clog2(TREE_DEPTH+1)-1:0]      set_lvl,
  input  logic [2:0]                           set_oct,
  input  logic [$clog2(TREE_DEPTH+1)-1:0]      keep_lvl,
  output logic [mon_pkg::CNT_W-1:0]            rd_cnt,
  output logic [mon_pkg::MASK_W-1:0]           rd_mask,
  output logic [mon_pkg::CNT_W-1:0]            root_cnt,
  output logic [mon_pkg::MASK_W-1:0]           root_mask
);
  import mon_pkg::*;

  localparam int IW    = $clog2(TREE_DEPTH+1);
  localparam int SAT_I = (MAX_POINTS < CNT_MAX) ? MAX_POINTS : CNT_MAX;
  localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(SAT_I);

  logic [CNT_W-1:0]  cnt_r    [TREE_DEPTH+1];
  logic [CNT_W-1:0]  cnt_nxt  [TREE_DEPTH+1];
  logic [MASK_W-1:0] mask_r   [TREE_DEPTH+1];
  logic [MASK_W-1:0] mask_nxt [TREE_DEPTH+1];

  always_comb begin
    for (int i = 0; i <= TREE_DEPTH; i++) begin
      cnt_nxt[i]  = cnt_r[i];
      mask_nxt[i] = mask_r[i];
      if (ctl.incr && (cnt_r[i] < CNT_SAT)) begin
        cnt_nxt[i] = cnt_r[i] + 1'b1;
      end
      if (ctl.mask_set && (set_lvl == IW'(i))) begin
        mask_nxt[i] = mask_r[i] | (8'd1 << set_oct);
      end
      if (ctl.clear_above && (IW'(i) > keep_lvl)) begin
        cnt_nxt[i]  = '0;
        mask_nxt[i] = '0;
      end
      if (ctl.clear_all) begin
        cnt_nxt[i]  = '0;
        mask_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i <= TREE_DEPTH; i++) begin
      if (!rst_n) begin
        cnt_r[i]  <= '0;
        mask_r[i] <= '0;
      end else begin
        cnt_r[i]  <= cnt_nxt[i];
        mask_r[i] <= mask_nxt[i];
      end
    end
  end

  assign rd_cnt    = cnt_r[rd_lvl];
  assign rd_mask   = mask_r[rd_lvl];
  assign root_cnt  = cnt_r[0];
  assign root_mask = mask_r[0];

endmodule

// File: hdl/mon_cell_unit.sv
// mon_cell_unit: shared shift and compare unit for one tree level
// prefix match, interval containment, node key and octant of the held key
// depends on mon_pkg
module mon_cell_unit #(
  parameter int TREE_DEPTH = 10
) (
  input  logic [3*TREE_DEPTH-1:0]        cur_key,
  input  logic [3*TREE_DEPTH-1:0]        held_key,
  input  logic [$clog2(TREE_DEPTH+2)-1:0] lvl,
  input  logic                           use_interval,
  input  logic [mon_pkg::CFG_W-1:0]      interval_begin,
  input  logic [mon_pkg::CFG_W-1:0]      interval_end,
  output logic                           prefix_eq,
  output logic                           owned,
  output logic [mon_pkg::NKEY_W-1:0]     cell_key,
  output logic [2:0]                     octant
);
  import mon_pkg::*;

  localparam int KW   = 3*TREE_DEPTH;
  localparam int LW   = $clog2(TREE_DEPTH+2);
  localparam int SHW  = $clog2(KW+1);
  localparam int MW   = SHW + LW;
  localparam int BW   = (KW+1 > NKEY_W) ? KW+1 : NKEY_W;

  logic [LW-1:0]  dlt;
  logic [MW-1:0]  sh_full;
  logic [SHW-1:0] sh;
  logic [KW-1:0]  pre_h;
  logic [KW-1:0]  pre_k;
  logic [BW-1:0]  nk_full;
  logic [BW-1:0]  cellbit;
  logic [BW-1:0]  cell_lo;
  logic [BW-1:0]  cell_hi;

  assign dlt     = LW'(TREE_DEPTH) - lvl;
  assign sh_full = MW'(dlt) * MW'(3);
  assign sh      = SHW'(sh_full);

  assign pre_h     = held_key >> sh;
  assign pre_k     = cur_key >> sh;
  assign prefix_eq = (pre_h == pre_k);
  assign octant    = pre_h[2:0];

  assign nk_full  = BW'({1'b1, held_key}) >> sh;
  assign cell_key = nk_full[NKEY_W-1:0];

  assign cellbit = BW'(1) << sh;
  assign cell_lo = BW'(held_key) & ~(cellbit - BW'(1));
  assign cell_hi = cell_lo + cellbit;
  assign owned   = !use_interval ||
                   ((BW'(interval_begin) <= cell_lo) && (cell_hi <= BW'(interval_end)));

endmodule

// File: hdl/morton_octree_node_builder_top.sv
// morton_octree_node_builder_top: linear octree node builder over sorted morton keys
// sequencer around the shared level unit and the level store
// depends on mon_pkg, mon_cell_unit, mon_level_store
//
// usage
//   in_*  : one morton key per transfer, in ascending order; in_tlast marks the
//           final key of a batch and flushes every open node, unless the batch hit an order error
//   out_* : octree nodes in post-order, children before parents, root last with
//           out_tlast high; out_tuser high marks the single order error result
//   cfg_* : register writes, always taken, meant only while the block is idle
// timing
//   one key at a time; in_tready is high only while the sequencer is idle
//   a key scans levels one by one through the one cell unit, down to the first
//   leaf level, then closes its nodes; the final key adds a second scan, its nodes
//   and the root
// reset
//   rst_n clears the batch state and restores register defaults
// stalls
//   results sit in one output register; the sequencer waits while it is full
//   and not taken, no result is dropped or repeated
module morton_octree_node_builder_top #(
  parameter int TREE_DEPTH = 10,
  parameter int MAX_POINTS = 65536
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // [29:0] point_key
  input  logic [31:0]                      in_tdata,
  input  logic                             in_tlast,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [30:0] tree_key, [34:31] tree_level, [51:35] point_count,
  // [59:52] octant_mask, [60] leaf_flag
  output logic [63:0]                      out_tdata,
  // [0] order_error
  output logic                             out_tuser,
  output logic                             out_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mon_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mon_pkg::CFG_W-1:0]        cfg_data
);
  import mon_pkg::*;

  localparam int KW = 3*TREE_DEPTH;
  localparam int LW = $clog2(TREE_DEPTH+2);
  localparam int IW = $clog2(TREE_DEPTH+1);
  localparam logic [LW-1:0] LVL_D = LW'(TREE_DEPTH);

  // configuration
  logic             use_int_r;
  logic [CFG_W-1:0] ibegin_r;
  logic [CFG_W-1:0] iend_r;

  // sequencer
  mon_state_t    state_r, state_nxt;
  logic [KW-1:0] key_r, key_nxt;
  logic          last_r, last_nxt;
  logic [KW-1:0] held_r, held_nxt;
  logic          held_v_r, held_v_nxt;
  logic          err_seen_r, err_seen_nxt;
  logic [LW-1:0] lvl_r, lvl_nxt;
  logic [LW-1:0] s_r, s_nxt;
  logic          sdone_r, sdone_nxt;
  logic          flush_r, flush_nxt;
  logic          leaf1_r, leaf1_nxt;

  // output register
  logic              ov_r, ov_nxt;
  logic [NKEY_W-1:0] o_key_r, o_key_nxt;
  logic [NLVL_W-1:0] o_lvl_r, o_lvl_nxt;
  logic [CNT_W-1:0]  o_cnt_r, o_cnt_nxt;
  logic [MASK_W-1:0] o_mask_r, o_mask_nxt;
  logic              o_leaf_r, o_leaf_nxt;
  logic              o_err_r, o_err_nxt;
  logic              o_end_r, o_end_nxt;

  logic              in_xfer;
  logic              can_emit;
  logic [KW-1:0]     in_key;
  logic [LW-1:0]     lvl_c;
  logic [LW-1:0]     lvl_dn;
  logic              prefix_eq;
  logic              cell_owned;
  logic [NKEY_W-1:0] cell_key;
  logic [2:0]        octant;
  logic [CNT_W-1:0]  rd_cnt;
  logic [MASK_W-1:0] rd_mask;
  logic [CNT_W-1:0]  root_cnt;
  logic [MASK_W-1:0] root_mask;
  mon_store_ctl_t    sctl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_int_r <= 1'b0;
      ibegin_r  <= '0;
      iend_r    <= INTERVAL_END_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_USE_INTERVAL:   use_int_r <= cfg_data[0];
        CFG_INTERVAL_BEGIN: ibegin_r  <= cfg_data;
        CFG_INTERVAL_END:   iend_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign in_key    = KW'(in_tdata[KEY_IN_W-1:0]);
  assign can_emit  = !ov_r || out_tready;
  assign lvl_c     = (lvl_r > LVL_D) ? LVL_D : lvl_r;
  assign lvl_dn    = lvl_r - 1'b1;

  mon_cell_unit #(
    .TREE_DEPTH(TREE_DEPTH)
  ) u_cell (
    .cur_key       (key_r),
    .held_key      (held_r),
    .lvl           (lvl_c),
    .use_interval  (use_int_r),
    .interval_begin(ibegin_r),
    .interval_end  (iend_r),
    .prefix_eq     (prefix_eq),
    .owned         (cell_owned),
    .cell_key      (cell_key),
    .octant        (octant)
  );

  mon_level_store #(
    .TREE_DEPTH(TREE_DEPTH),
    .MAX_POINTS(MAX_POINTS)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (sctl),
    .rd_lvl   (lvl_c[IW-1:0]),
    .set_lvl  (lvl_dn[IW-1:0]),
    .set_oct  (octant),
    .keep_lvl (s_r[IW-1:0]),
    .rd_cnt   (rd_cnt),
    .rd_mask  (rd_mask),
    .root_cnt (root_cnt),
    .root_mask(root_mask)
  );

  always_comb begin
    state_nxt    = state_r;
    key_nxt      = key_r;
    last_nxt     = last_r;
    held_nxt     = held_r;
    held_v_nxt   = held_v_r;
    err_seen_nxt = err_seen_r;
    lvl_nxt      = lvl_r;
    s_nxt        = s_r;
    sdone_nxt    = sdone_r;
    flush_nxt    = flush_r;
    leaf1_nxt    = leaf1_r;
    sctl         = '0;

    ov_nxt     = ov_r && !out_tready;
    o_key_nxt  = o_key_r;
    o_lvl_nxt  = o_lvl_r;
    o_cnt_nxt  = o_cnt_r;
    o_mask_nxt = o_mask_r;
    o_leaf_nxt = o_leaf_r;
    o_err_nxt  = o_err_r;
    o_end_nxt  = o_end_r;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          key_nxt  = in_key;
          last_nxt = in_tlast;
          if (err_seen_r) begin
            if (in_tlast) begin
              sctl.clear_all = 1'b1;
              held_nxt       = '0;
              held_v_nxt     = 1'b0;
              err_seen_nxt   = 1'b0;
            end
          end else if (held_v_r && (in_key < held_r)) begin
            state_nxt = ST_ERR;
          end else if (held_v_r) begin
            state_nxt = ST_SCAN;
            lvl_nxt   = LW'(1);
            s_nxt     = '0;
            sdone_nxt = 1'b0;
            flush_nxt = 1'b0;
          end else begin
            state_nxt = ST_INCR;
          end
        end
      end
      ST_ERR: begin
        if (can_emit) begin
          ov_nxt     = 1'b1;
          o_key_nxt  = '0;
          o_lvl_nxt  = '0;
          o_cnt_nxt  = '0;
          o_mask_nxt = '0;
          o_leaf_nxt = 1'b0;
          o_err_nxt  = 1'b1;
          o_end_nxt  = last_r;
          state_nxt  = ST_IDLE;
          if (last_r) begin
            sctl.clear_all = 1'b1;
            held_nxt       = '0;
            held_v_nxt     = 1'b0;
          end else begin
            err_seen_nxt = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (!sdone_r && (lvl_r <= LVL_D) && prefix_eq) begin
          s_nxt   = lvl_r;
          lvl_nxt = lvl_r + 1'b1;
        end else if (!sdone_r && (lvl_r > LVL_D)) begin
          // same cell at full depth, nothing closes
          state_nxt = ST_INCR;
        end else begin
          sdone_nxt = 1'b1;
          if ((lvl_r == LVL_D) || ((rd_cnt == CNT_W'(1)) && cell_owned)) begin
            state_nxt = ST_EMIT;
            leaf1_nxt = 1'b1;
          end else begin
            lvl_nxt = lvl_r + 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (can_emit) begin
          ov_nxt        = 1'b1;
          o_key_nxt     = cell_key;
          o_lvl_nxt     = NLVL_W'(lvl_r);
          o_cnt_nxt     = rd_cnt;
          o_mask_nxt    = rd_mask;
          o_leaf_nxt    = leaf1_r;
          o_err_nxt     = 1'b0;
          o_end_nxt     = 1'b0;
          leaf1_nxt     = 1'b0;
          sctl.mask_set = 1'b1;
          if (lvl_dn == s_r) begin
            sctl.clear_above = 1'b1;
            state_nxt        = flush_r ? ST_ROOT : ST_INCR;
          end else begin
            lvl_nxt = lvl_dn;
          end
        end
      end
      ST_INCR: begin
        sctl.incr  = 1'b1;
        held_nxt   = key_r;
        held_v_nxt = 1'b1;
        if (last_r) begin
          state_nxt = ST_SCAN;
          flush_nxt = 1'b1;
          sdone_nxt = 1'b1;
          s_nxt     = '0;
          lvl_nxt   = LW'(1);
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ROOT: begin
        if (can_emit) begin
          ov_nxt         = 1'b1;
          o_key_nxt      = NKEY_W'(1);
          o_lvl_nxt      = '0;
          o_cnt_nxt      = root_cnt;
          o_mask_nxt     = root_mask;
          o_leaf_nxt     = (root_mask == '0);
          o_err_nxt      = 1'b0;
          o_end_nxt      = 1'b1;
          sctl.clear_all = 1'b1;
          held_nxt       = '0;
          held_v_nxt     = 1'b0;
          err_seen_nxt   = 1'b0;
          flush_nxt      = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      held_r     <= '0;
      held_v_r   <= 1'b0;
      err_seen_r <= 1'b0;
      lvl_r      <= LW'(1);
      s_r        <= '0;
      sdone_r    <= 1'b0;
      flush_r    <= 1'b0;
      leaf1_r    <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      held_r     <= held_nxt;
      held_v_r   <= held_v_nxt;
      err_seen_r <= err_seen_nxt;
      lvl_r      <= lvl_nxt;
      s_r        <= s_nxt;
      sdone_r    <= sdone_nxt;
      flush_r    <= flush_nxt;
      leaf1_r    <= leaf1_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    last_r   <= last_nxt;
    o_key_r  <= o_key_nxt;
    o_lvl_r  <= o_lvl_nxt;
    o_cnt_r  <= o_cnt_nxt;
    o_mask_r <= o_mask_nxt;
    o_leaf_r <= o_leaf_nxt;
    o_err_r  <= o_err_nxt;
    o_end_r  <= o_end_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {3'b000, o_leaf_r, o_mask_r, o_cnt_r, o_lvl_r, o_key_r};
  assign out_tuser  = o_err_r;
  assign out_tlast  = o_end_r;

endmodule
